/* src/erq_pkg.sv */
// Shared types and constants for the Euler-angle rotation matrix block.
package erq_pkg;

  localparam int ANGLE_W   = 12;  // angle bits used as a table index
  localparam int HALF_W    = 16;  // one signed half of a table word
  localparam int WORD_W    = 32;  // packed sine/cosine word
  localparam int ELEM_W    = 16;  // matrix element
  localparam int OUT_DEPTH = 4;   // result buffer entries
  localparam int PTR_W     = $clog2(OUT_DEPTH) + 1;
  localparam int CNT_W     = $clog2(OUT_DEPTH) + 1;

  // item kinds
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t wa;
    word_t wb;
    word_t wc;
  } words_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
  } mat_t;

endpackage

/* src/erq_ram.sv */
// Generic single-port synchronous RAM with registered read data.
module erq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/erq_math.sv */
// Two-stage multiply pipeline forming the nine matrix elements from three words.
module erq_math import erq_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  words_t words_i,
  output logic   out_valid_o,
  output mat_t   out_o
);

  function automatic logic signed [WORD_W-1:0] sh32(input logic signed [WORD_W-1:0] x);
    return x >>> FRAC_BITS;
  endfunction

  function automatic logic [ELEM_W-1:0] sh16(input logic signed [WORD_W-1:0] x);
    logic signed [WORD_W-1:0] s;
    s = x >>> FRAC_BITS;
    return s[ELEM_W-1:0];
  endfunction

  // halves of the three words
  logic signed [HALF_W-1:0] lo_a, hi_a, lo_b, hi_b, lo_c, hi_c;
  assign lo_a = words_i.wa[HALF_W-1:0];
  assign hi_a = words_i.wa[WORD_W-1:HALF_W];
  assign lo_b = words_i.wb[HALF_W-1:0];
  assign hi_b = words_i.wb[WORD_W-1:HALF_W];
  assign lo_c = words_i.wc[HALF_W-1:0];
  assign hi_c = words_i.wc[WORD_W-1:HALF_W];

  // stage 1: first-level products
  logic                     s1_v_q;
  logic signed [WORD_W-1:0] p_ab_q, p_ac_q, p_al_q, p_cb_q, p_alc_q;
  logic signed [WORD_W-1:0] p_lcb_q, p_ahc_q, p_bla_q, p_bha_q;
  logic signed [HALF_W-1:0] lo_b_q, lo_c_q, hi_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      p_ab_q  <= WORD_W'(lo_a) * WORD_W'(lo_b);
      p_ac_q  <= WORD_W'(hi_a) * WORD_W'(hi_c);
      p_al_q  <= WORD_W'(hi_a) * WORD_W'(lo_c);
      p_cb_q  <= WORD_W'(hi_c) * WORD_W'(hi_b);
      p_alc_q <= WORD_W'(lo_a) * WORD_W'(lo_c);
      p_lcb_q <= WORD_W'(lo_c) * WORD_W'(hi_b);
      p_ahc_q <= WORD_W'(lo_a) * WORD_W'(hi_c);
      p_bla_q <= WORD_W'(hi_b) * WORD_W'(lo_a);
      p_bha_q <= WORD_W'(hi_b) * WORD_W'(hi_a);
      lo_b_q  <= lo_b;
      lo_c_q  <= lo_c;
      hi_c_q  <= hi_c;
    end
  end

  // stage 2: chained products of shifted terms; low 32 bits suffice
  logic signed [WORD_W-1:0] t_ab, t_ac, t_al;
  assign t_ab = sh32(p_ab_q);
  assign t_ac = sh32(p_ac_q);
  assign t_al = sh32(p_al_q);

  logic                     s2_v_q;
  logic signed [WORD_W-1:0] q01_q, q02_q, q11_q, q12_q;
  logic        [ELEM_W-1:0] e_al_q, e_ac_q, e_alc_q, e_ahc_q;
  logic        [ELEM_W-1:0] r00_q, r10_q, r20_q, r21_q, r22_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      q01_q   <= t_ab * WORD_W'(hi_c_q);
      q02_q   <= t_ac * WORD_W'(lo_b_q);
      q11_q   <= t_ab * WORD_W'(lo_c_q);
      q12_q   <= t_al * WORD_W'(lo_b_q);
      e_al_q  <= t_al[ELEM_W-1:0];
      e_ac_q  <= t_ac[ELEM_W-1:0];
      e_alc_q <= sh16(p_alc_q);
      e_ahc_q <= sh16(p_ahc_q);
      r00_q   <= sh16(p_cb_q);
      r10_q   <= sh16(p_lcb_q);
      r20_q   <= -lo_b_q;
      r21_q   <= sh16(p_bla_q);
      r22_q   <= sh16(p_bha_q);
    end
  end

  // final sums wrap at 16 bits
  always_comb begin
    out_o.r00 = r00_q;
    out_o.r01 = sh16(q01_q) - e_al_q;
    out_o.r02 = sh16(q02_q) + e_alc_q;
    out_o.r10 = r10_q;
    out_o.r11 = sh16(q11_q) + e_ac_q;
    out_o.r12 = sh16(q12_q) - e_ahc_q;
    out_o.r20 = r20_q;
    out_o.r21 = r21_q;
    out_o.r22 = r22_q;
  end

  assign out_valid_o = s2_v_q;

endmodule

/* src/euler_rotation_matrix_q12.sv */
// Top level: Euler-angle rotation matrix builder over a sine/cosine table RAM.
//
// Builds a 3x3 Q(FRAC_BITS) rotation matrix from three angle indices. Each
// item is either a load (action_i = 0), which writes table_word_i into the
// table at table_index_i, or a compute (action_i = 1), which looks up the
// words for angle_a_i, angle_b_i and angle_c_i (low 12 bits, taken modulo
// TABLE_DEPTH) and returns one matrix. Loads give no result. Every table
// entry must be loaded before a compute reads it; there is no clearing pass.
// A compute makes three reads, A, B and C, through the single port of the
// table RAM, so no new item is taken until its reads B and C are issued.
// Words A and B wait in word registers until word C leaves the RAM read
// register; the math unit then writes the matrix into the result buffer. Up
// to four computes may be pending while the output side stalls; beyond the
// reads B and C of a compute, input is held off only when four are pending.
module euler_rotation_matrix_q12 import erq_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  parameter int FRAC_BITS   = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [11:0]              table_index_i,
  input  logic [31:0]              table_word_i,
  input  logic [15:0]              angle_a_i,
  input  logic [15:0]              angle_b_i,
  input  logic [15:0]              angle_c_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ELEM_W-1:0] r00_o,
  output logic signed [ELEM_W-1:0] r01_o,
  output logic signed [ELEM_W-1:0] r02_o,
  output logic signed [ELEM_W-1:0] r10_o,
  output logic signed [ELEM_W-1:0] r11_o,
  output logic signed [ELEM_W-1:0] r12_o,
  output logic signed [ELEM_W-1:0] r20_o,
  output logic signed [ELEM_W-1:0] r21_o,
  output logic signed [ELEM_W-1:0] r22_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // read sequencer phases
  localparam logic [1:0] PH_IDLE = 2'd0;  // free; a compute issues read A here
  localparam logic [1:0] PH_RD_B = 2'd1;
  localparam logic [1:0] PH_RD_C = 2'd2;

  // which word the RAM returns this cycle
  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_A    = 2'd1;
  localparam logic [1:0] RK_B    = 2'd2;
  localparam logic [1:0] RK_C    = 2'd3;

  // masked 12-bit angle reduced modulo TABLE_DEPTH by shifted compare and
  // subtract; with depth at least 256 the quotient fits in the five bits tried
  function automatic logic [AW-1:0] tbl_idx(input logic [ANGLE_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    for (int k = ANGLE_W - 8; k >= 0; k--) begin
      if (x >= (32'(TABLE_DEPTH) << k)) begin
        x = x - (32'(TABLE_DEPTH) << k);
      end
    end
    return x[AW-1:0];
  endfunction

  logic [1:0]    phase_q, phase_d;
  logic [1:0]    rk_q, rk_d;
  logic [AW-1:0] b_idx_q, c_idx_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic in_fire, out_fire, fire_load, fire_comp;

  assign in_ready_o = (phase_q == PH_IDLE) && (cnt_q != CNT_W'(OUT_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;
  assign fire_load  = in_fire && (action_i == ACT_LOAD);
  assign fire_comp  = in_fire && (action_i == ACT_COMPUTE);
  assign out_fire   = out_valid_o && out_ready_i;

  // ---------------------------------------------------------------------------
  // Table RAM port: load writes and read A come straight from the input item,
  // reads B and C from the indices captured at accept. A load can only land
  // in the idle phase, so it never slips between the reads of one compute.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] ram_addr;
  word_t         ram_rdata;

  always_comb begin
    case (phase_q)
      PH_RD_B: ram_addr = b_idx_q;
      PH_RD_C: ram_addr = c_idx_q;
      default: begin
        if (action_i == ACT_LOAD) begin
          ram_addr = tbl_idx(table_index_i);
        end else begin
          ram_addr = tbl_idx(angle_a_i[ANGLE_W-1:0]);
        end
      end
    endcase
  end

  erq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (fire_load),
    .addr_i  (ram_addr),
    .wdata_i (table_word_i),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    phase_d = phase_q;
    rk_d    = RK_NONE;
    case (phase_q)
      PH_IDLE: begin
        if (fire_comp) begin
          phase_d = PH_RD_B;
          rk_d    = RK_A;
        end
      end
      PH_RD_B: begin
        phase_d = PH_RD_C;
        rk_d    = RK_B;
      end
      PH_RD_C: begin
        phase_d = PH_IDLE;
        rk_d    = RK_C;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // pending computes: accepted but result not yet taken; bounds the buffer
  always_comb begin
    cnt_d = cnt_q;
    if (fire_comp && !out_fire) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!fire_comp && out_fire) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rk_q    <= RK_NONE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rk_q    <= rk_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_comp) begin
      b_idx_q <= tbl_idx(angle_b_i[ANGLE_W-1:0]);
      c_idx_q <= tbl_idx(angle_c_i[ANGLE_W-1:0]);
    end
  end

  // gather words A and B; word C goes to the math unit straight from the RAM
  word_t wa_q, wb_q;

  always_ff @(posedge clk_i) begin
    if (rk_q == RK_A) begin
      wa_q <= ram_rdata;
    end
    if (rk_q == RK_B) begin
      wb_q <= ram_rdata;
    end
  end

  words_t math_words;
  logic   math_v;
  mat_t   math_mat;

  assign math_words.wa = wa_q;
  assign math_words.wb = wb_q;
  assign math_words.wc = ram_rdata;

  erq_math #(
    .FRAC_BITS (FRAC_BITS)
  ) u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rk_q == RK_C),
    .words_i     (math_words),
    .out_valid_o (math_v),
    .out_o       (math_mat)
  );

  // ---------------------------------------------------------------------------
  // Result buffer. The pending count keeps it from overflowing, so the math
  // pipeline never has to stall.
  // ---------------------------------------------------------------------------
  mat_t             fifo_q [OUT_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (math_v) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (out_fire) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (math_v) begin
      fifo_q[wptr_q[PTR_W-2:0]] <= math_mat;
    end
  end

  mat_t head;
  assign head        = fifo_q[rptr_q[PTR_W-2:0]];
  assign out_valid_o = (wptr_q != rptr_q);

  assign r00_o = head.r00;
  assign r01_o = head.r01;
  assign r02_o = head.r02;
  assign r10_o = head.r10;
  assign r11_o = head.r11;
  assign r12_o = head.r12;
  assign r20_o = head.r20;
  assign r21_o = head.r21;
  assign r22_o = head.r22;

endmodule

/* src/erq_checker.sv */
// Port-level checker for the rotation matrix block, bound to the top level.
module erq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] r00_o,
  input logic signed [15:0] r01_o,
  input logic signed [15:0] r02_o,
  input logic signed [15:0] r10_o,
  input logic signed [15:0] r11_o,
  input logic signed [15:0] r12_o,
  input logic signed [15:0] r20_o,
  input logic signed [15:0] r21_o,
  input logic signed [15:0] r22_o
);

  logic comp_fire, out_fire;
  logic [7:0] pend_q;

  assign comp_fire = in_valid_i && in_ready_o && action_i;
  assign out_fire  = out_valid_o && out_ready_i;

  // computes accepted and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(comp_fire) - 8'(out_fire);
    end
  end

  // a result only ever answers an outstanding compute
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 8'd0))
    else $error("result with no outstanding compute");

  // a compute holds off input while its reads B and C use the table port
  a_comp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_fire |=> (!in_ready_o ##1 !in_ready_o))
    else $error("input taken while table reads in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(r00_o) && $stable(r01_o) && $stable(r02_o) && $stable(r10_o) &&
       $stable(r11_o) && $stable(r12_o) && $stable(r20_o) && $stable(r21_o) &&
       $stable(r22_o)))
    else $error("result changed while stalled");

endmodule

bind euler_rotation_matrix_q12 erq_checker u_erq_checker (.*);
